// ===== rtl/core/pcms_pkg.sv =====
package pcms_pkg;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam int unsigned OpWidth = 2;

endpackage

// ===== rtl/core/pcms_ram.sv =====
module pcms_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/pcms_stat.sv =====
// Turns a cell's sums into mean and deviation. One read at a time. The mean
// comes from a restoring divider, the deviation from a bit-serial square
// root search; the wide products are built from 32-bit partial products.
module pcms_stat #(
  parameter int unsigned CountWidth  = 16,
  parameter int unsigned SampleWidth = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [39:0]     sum_i,
  input  logic [63:0]            sq_i,
  input  logic [CountWidth-1:0]  count_i,
  output logic                   done_o,
  output logic signed [SampleWidth-1:0] mean_o,
  output logic [SampleWidth-1:0] dev_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_PROD, S_DIV, S_ROOT, S_CHECK, S_DONE
  } state_e;

  state_e state_q;
  logic [5:0]   step_q;
  logic [1:0]   part_q;
  logic         neg_q;
  logic [39:0]  smag_q;
  logic [CountWidth-1:0] n_q;
  logic [63:0]  sq_q;
  logic [127:0] acc_q;   // product sums: n*sq, then (trial*n)^2
  logic [127:0] num_q;
  logic [41:0]  rem_q;   // divider remainder
  logic [41:0]  quo_q;
  logic [SampleWidth-1:0] dev_q;
  logic [SampleWidth-1:0] trial_q;
  logic [SampleWidth+CountWidth-1:0] tn_q;

  // One 32x32 partial product per cycle.
  logic [31:0] pa, pb;
  logic [63:0] pp;
  assign pp = pa * pb;

  logic [63:0] smag64, tn64, nn64;
  assign smag64 = {24'd0, smag_q};
  assign tn64   = 64'(tn_q);
  assign nn64   = 64'(n_q);

  // Partial-product bookkeeping: phase step_q[2] picks a product, part_q the
  // pair of 32-bit halves.
  always_comb begin
    pa = '0;
    pb = '0;
    unique case (state_q)
      S_PROD: begin
        if (step_q[2] == 1'b0) begin
          pa = part_q[0] ? nn64[63:32] : nn64[31:0];
          pb = part_q[1] ? sq_q[63:32] : sq_q[31:0];
        end else begin
          pa = part_q[0] ? smag64[63:32] : smag64[31:0];
          pb = part_q[1] ? smag64[63:32] : smag64[31:0];
        end
      end
      S_CHECK: begin
        pa = part_q[0] ? tn64[63:32] : tn64[31:0];
        pb = part_q[1] ? tn64[63:32] : tn64[31:0];
      end
      default: ;
    endcase
  end

  logic [127:0] pp_sh;
  assign pp_sh = {64'd0, pp} << (7'(part_q[0]) * 7'd32 + 7'(part_q[1]) * 7'd32);

  logic [41:0] den2;
  assign den2 = 42'({n_q, 1'b0});

  logic [41:0] dividend;
  assign dividend = {1'b0, smag_q, 1'b0} + 42'(n_q);

  assign done_o = (state_q == S_DONE);
  assign mean_o = neg_q ? -SampleWidth'(quo_q) : SampleWidth'(quo_q);
  assign dev_o  = dev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      part_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            neg_q   <= sum_i[39];
            smag_q  <= sum_i[39] ? 40'(-sum_i) : 40'(sum_i);
            n_q     <= count_i;
            sq_q    <= sq_i;
            acc_q   <= '0;
            num_q   <= '0;
            step_q  <= '0;
            part_q  <= '0;
            state_q <= S_PROD;
          end
        end
        S_PROD: begin
          // a = n*sq accumulates in acc_q, b = smag^2 in num_q.
          if (step_q[2] == 1'b0) acc_q <= acc_q + pp_sh;
          else num_q <= num_q + pp_sh;
          part_q <= part_q + 2'd1;
          if (part_q == 2'd3) begin
            if (step_q[2]) begin
              state_q <= S_DIV;
              step_q  <= '0;
              rem_q   <= '0;
              quo_q   <= '0;
            end else begin
              step_q <= 6'd4;
            end
          end
        end
        S_DIV: begin
          if (step_q == 6'd0) begin
            num_q <= (acc_q <= num_q) ? 128'd0 : acc_q - num_q;
          end
          begin : div_step
            logic [41:0] r;
            r = {rem_q[40:0], dividend[6'd41 - step_q]};
            if ({1'b0, r} >= {1'b0, den2}) begin
              rem_q <= r - den2;
              quo_q <= {quo_q[40:0], 1'b1};
            end else begin
              rem_q <= r;
              quo_q <= {quo_q[40:0], 1'b0};
            end
          end
          if (step_q == 6'd41) begin
            dev_q   <= '0;
            step_q  <= 6'(SampleWidth - 2);
            state_q <= S_ROOT;
          end else begin
            step_q <= step_q + 6'd1;
          end
        end
        S_ROOT: begin
          trial_q <= dev_q | (SampleWidth'(1) << step_q);
          tn_q    <= (SampleWidth+CountWidth)'(dev_q | (SampleWidth'(1) << step_q)) *
                     (SampleWidth+CountWidth)'(n_q);
          acc_q   <= '0;
          part_q  <= '0;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          part_q <= part_q + 2'd1;
          if (part_q != 2'd3) begin
            acc_q <= acc_q + pp_sh;
          end else begin
            if (acc_q + pp_sh <= num_q) dev_q <= trial_q;
            if (step_q == 6'd0) state_q <= S_DONE;
            else begin
              step_q  <= step_q - 6'd1;
              state_q <= S_ROOT;
            end
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/per_cell_mean_stddev.sv =====
// Accumulate and clear go through the read-modify-write path, S_READ then
// S_UPDATE; a read of an empty cell has its beat set up in S_UPDATE, any
// other read once the divider and the square root in pcms_stat are done.
// No new item is taken until accumulate and clear have finished the
// memory read, update and write back; reads hold the input for the divider
// and the bit-serial square root until their beat is taken. Reset clears
// control and sets the missing value to the most negative code; cell
// memories are not cleared.
module per_cell_mean_stddev
  import pcms_pkg::*;
#(
  parameter int unsigned GRID_CELLS   = 4096,
  parameter int unsigned COUNT_WIDTH  = 16,
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic signed [23:0]  cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic [11:0]         cell_index_i,
  input  logic signed [23:0]  sample_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [11:0]         result_cell_o,
  output logic signed [23:0]  mean_value_o,
  output logic signed [23:0]  deviation_value_o,
  output logic [15:0]         sample_count_o,
  output logic                has_data_o
);

  localparam int unsigned AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int unsigned MW = 40 + 64 + COUNT_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_UPDATE, S_STAT, S_OUT
  } state_e;

  state_e state_q;
  logic signed [23:0] miss_q;
  logic [OpWidth-1:0] op_q;
  logic [11:0] cell_q;
  logic signed [SAMPLE_WIDTH-1:0] samp_q;

  // Missing value as seen at the sample width.
  logic signed [SAMPLE_WIDTH-1:0] miss_s;
  assign miss_s = miss_q[SAMPLE_WIDTH-1:0];

  logic in_range;
  assign in_range = 32'(cell_index_i) < GRID_CELLS;
  assign in_ready_o = (state_q == S_IDLE);

  // The memory is addressed by the incoming beat while idle and by the
  // captured cell afterwards, so the word stays put through the update.
  logic [AW-1:0] raddr;
  assign raddr = (state_q == S_IDLE) ? cell_index_i[AW-1:0] : cell_q[AW-1:0];

  // All three per-cell stores share one memory word: sum, squares, count.
  logic          we;
  logic [MW-1:0] wdata, rdata;
  pcms_ram #(.Width(MW), .Depth(GRID_CELLS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cell_q[AW-1:0]),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic signed [39:0] r_sum;
  logic [63:0] r_sq;
  logic [COUNT_WIDTH-1:0] r_cnt;
  assign r_sum = rdata[MW-1 -: 40];
  assign r_sq  = rdata[COUNT_WIDTH +: 64];
  assign r_cnt = rdata[COUNT_WIDTH-1:0];

  logic [SAMPLE_WIDTH-1:0] mag;
  assign mag = samp_q[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-samp_q) : SAMPLE_WIDTH'(samp_q);

  logic skip;
  assign skip = (samp_q == miss_s) || (r_cnt == {COUNT_WIDTH{1'b1}});

  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    if (state_q == S_UPDATE) begin
      if (op_q == OP_CLEAR) begin
        we    = 1'b1;
        wdata = '0;
      end else if (op_q == OP_ACCUM && !skip) begin
        we    = 1'b1;
        wdata = {r_sum + 40'(samp_q), r_sq + 64'(mag) * 64'(mag), r_cnt + 1'b1};
      end
    end
  end

  logic stat_done;
  logic signed [SAMPLE_WIDTH-1:0] stat_mean;
  logic [SAMPLE_WIDTH-1:0] stat_dev;
  logic [COUNT_WIDTH-1:0] cnt_q;
  pcms_stat #(.CountWidth(COUNT_WIDTH), .SampleWidth(SAMPLE_WIDTH)) u_stat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == S_UPDATE && op_q == OP_READ && r_cnt != '0),
    .sum_i  (r_sum),
    .sq_i   (r_sq),
    .count_i(r_cnt),
    .done_o (stat_done),
    .mean_o (stat_mean),
    .dev_o  (stat_dev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      miss_q      <= 24'sh800000;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) miss_q <= cfg_wdata_i;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_range && operation_i != OP_NONE) begin
            op_q    <= operation_i;
            cell_q  <= cell_index_i;
            samp_q  <= sample_value_i[SAMPLE_WIDTH-1:0];
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_UPDATE;
        S_UPDATE: begin
          if (op_q != OP_READ) state_q <= S_IDLE;
          else begin
            cnt_q         <= r_cnt;
            result_cell_o <= cell_q;
            sample_count_o <= 16'(r_cnt);
            if (r_cnt == '0) begin
              mean_value_o      <= 24'(miss_s);
              deviation_value_o <= 24'(miss_s);
              has_data_o        <= 1'b0;
              out_valid_o       <= 1'b1;
              state_q           <= S_OUT;
            end else begin
              state_q <= S_STAT;
            end
          end
        end
        S_STAT: begin
          if (stat_done) begin
            mean_value_o      <= 24'(stat_mean);
            deviation_value_o <= 24'(stat_dev);
            has_data_o        <= cnt_q != '0;
            out_valid_o       <= 1'b1;
            state_q           <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/pcms_checker.sv =====
module pcms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] sample_count_o,
  input logic        has_data_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("out beat dropped");
  a_has: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> has_data_o == (sample_count_o != 16'd0)) else $error("has_data");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input open during output");
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(sample_count_o) && $stable(has_data_o))
    else $error("out beat changed while waiting");

endmodule

bind per_cell_mean_stddev pcms_checker u_chk (.*);

// ===== tb/tb_per_cell_mean_stddev.sv =====
module tb_per_cell_mean_stddev;
  import pcms_pkg::*;

  localparam int unsigned Cells      = 4096;
  localparam int unsigned CountMax   = 65535;
  // A read holds the datapath for the divider and the bit-serial root, so
  // the settle time after the last result covers one full read.
  localparam int unsigned SettleCycles = 250;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned PoolSize   = 16;

  // One expected read beat, laid out like the output ports.
  typedef struct packed {
    logic [11:0]        cell_id;
    logic signed [23:0] mean;
    logic signed [23:0] dev;
    logic [15:0]        count;
    logic               has;
  } cell_stats_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic signed [23:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i = OP_NONE;
  logic [11:0]        cell_index_i = '0;
  logic signed [23:0] sample_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [11:0]        result_cell_o;
  logic signed [23:0] mean_value_o;
  logic signed [23:0] deviation_value_o;
  logic [15:0]        sample_count_o;
  logic               has_data_o;

  // Shadow copy of the cell memories and the missing-value register.
  longint             cell_sum [Cells];
  logic [63:0]        cell_square_sum [Cells];
  int unsigned        cell_count [Cells];
  logic signed [23:0] missing_code;

  cell_stats_t        pending_stats[$];
  int unsigned        errors = 0;
  bit                 idling_on = 1'b1;
  int unsigned        holdoff_requests = 0;
  int unsigned        idle_cycles = 0;
  logic [11:0]        cell_pool [PoolSize];

  always #5 clk_i = ~clk_i;

  per_cell_mean_stddev uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .cell_index_i      (cell_index_i),
    .sample_value_i    (sample_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_cell_o     (result_cell_o),
    .mean_value_o      (mean_value_o),
    .deviation_value_o (deviation_value_o),
    .sample_count_o    (sample_count_o),
    .has_data_o        (has_data_o)
  );

  // Works out the statistics of one cell exactly as the hardware must: the
  // mean is rounded half away from zero, and the deviation is the largest d
  // with (d*n)^2 <= n*sumsq - sum^2, which needs 128-bit headroom.
  function automatic cell_stats_t cell_statistics(logic [11:0] cell_id);
    cell_stats_t  st;
    longint       s;
    logic [63:0]  smag;
    logic [63:0]  n;
    logic [63:0]  q;
    logic [127:0] spread;
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] tn;
    logic [23:0]  dev;
    logic [23:0]  trial;
    st.cell_id = cell_id;
    n        = cell_count[cell_id];
    st.count = n[15:0];
    if (n == 0) begin
      st.mean = missing_code;
      st.dev  = missing_code;
      st.has  = 1'b0;
      return st;
    end
    s      = cell_sum[cell_id];
    smag   = (s < 0) ? -s : s;
    q      = (2 * smag + n) / (2 * n);
    st.mean = (s < 0) ? -q[23:0] : q[23:0];
    a      = 128'(n) * 128'(cell_square_sum[cell_id]);
    b      = 128'(smag) * 128'(smag);
    spread = (a <= b) ? 128'd0 : a - b;
    dev    = '0;
    for (int bit_pos = 22; bit_pos >= 0; bit_pos--) begin
      trial = dev | (24'd1 << bit_pos);
      tn    = 128'(trial) * 128'(n);
      if (tn * tn <= spread) dev = trial;
    end
    st.dev = dev;
    st.has = 1'b1;
    return st;
  endfunction

  // Applies one accepted item to the shadow memories; a read queues a beat.
  task automatic apply_item(op_e op, logic [11:0] cell_id, logic signed [23:0] sample);
    logic [63:0] mag;
    case (op)
      OP_ACCUM: begin
        if (sample != missing_code && cell_count[cell_id] < CountMax) begin
          mag = (sample < 0) ? -longint'(sample) : longint'(sample);
          cell_sum[cell_id]        += sample;
          cell_square_sum[cell_id] += mag * mag;
          cell_count[cell_id]      += 1;
        end
      end
      OP_CLEAR: begin
        cell_sum[cell_id]        = 0;
        cell_square_sum[cell_id] = '0;
        cell_count[cell_id]      = 0;
      end
      OP_READ: pending_stats.push_back(cell_statistics(cell_id));
      default: ;
    endcase
  endtask

  // Offers one item and returns right after the edge that accepts it. Valid
  // stays high after acceptance, so back-to-back items never drop it.
  task automatic send_item(op_e op, logic [11:0] cell_id, logic signed [23:0] sample);
    bit ready_seen;
    if (idling_on && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    cell_index_i   <= cell_id;
    sample_value_i <= sample;
    do begin
      @(negedge clk_i);
      ready_seen = in_ready_o;
      @(posedge clk_i);
    end while (!ready_seen);
    apply_item(op, cell_id, sample);
  endtask

  // Lowers valid and waits until every queued beat has arrived, then lets a
  // full read latency pass so no accumulate is still in flight.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_missing(logic signed [23:0] code);
    drain_and_settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    missing_code = code;
    @(posedge clk_i);
  endtask

  // Empty cells report the missing code, the sample extremes land in the
  // sums, and a sample equal to the missing code is skipped.
  task automatic test_extremes_and_missing();
    send_item(OP_CLEAR, 12'd0, '0);
    send_item(OP_CLEAR, 12'd4095, '0);
    send_item(OP_READ, 12'd0, '0);
    send_item(OP_ACCUM, 12'd0, 24'sh7FFFFF);
    send_item(OP_ACCUM, 12'd0, -24'sh800000);
    send_item(OP_ACCUM, 12'd0, 24'sh7FFFFF);
    send_item(OP_READ, 12'd0, '0);
    send_item(OP_ACCUM, 12'd4095, -24'sd1);
    send_item(OP_ACCUM, 12'd4095, 24'sd2);
    send_item(OP_READ, 12'd4095, '0);
    write_missing(24'sd0);
    send_item(OP_ACCUM, 12'd4095, 24'sd0);
    send_item(OP_ACCUM, 12'd4095, -24'sh800000);
    send_item(OP_READ, 12'd4095, '0);
    send_item(OP_CLEAR, 12'd4095, '0);
    send_item(OP_READ, 12'd4095, '0);
    write_missing(24'sh7FFFFF);
    send_item(OP_READ, 12'd4095, '0);
    send_item(OP_ACCUM, 12'd0, 24'sh7FFFFF);
    send_item(OP_READ, 12'd0, '0);
  endtask

  // Operation 3 must be swallowed without a beat, on any cell.
  task automatic test_unknown_operation();
    send_item(OP_NONE, 12'd0, 24'sh123456);
    send_item(OP_NONE, 12'hAAA, -24'sd5);
    send_item(OP_READ, 12'd0, '0);
  endtask

  // Back-to-back accumulates of mixed sign into one cell with idling off,
  // so every update reads the word written just before it.
  task automatic test_dense_accumulate();
    idling_on = 1'b0;
    send_item(OP_CLEAR, 12'd7, '0);
    for (int i = 0; i < 40; i++) begin
      send_item(OP_ACCUM, 12'd7, (i % 3 == 0) ? -24'sd4096 : 24'sd12288);
    end
    send_item(OP_READ, 12'd7, '0);
    idling_on = 1'b1;
  endtask

  // The receiver holds off while reads keep coming, so the block backs up
  // and stalls its input; then the sender pauses until all beats are back.
  task automatic test_backpressure();
    send_item(OP_CLEAR, 12'h555, '0);
    send_item(OP_ACCUM, 12'h555, 24'sd300);
    holdoff_requests++;
    for (int i = 0; i < 8; i++) begin
      send_item(OP_READ, 12'h555, '0);
      send_item(OP_ACCUM, 12'h555, 24'($urandom_range(16000)) - 24'sd8000);
    end
    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    send_item(OP_READ, 12'h555, '0);
  endtask

  task automatic send_random_item();
    int unsigned        pick;
    logic [11:0]        cell_id;
    logic signed [23:0] sample;
    pick    = $urandom_range(99);
    cell_id = cell_pool[$urandom_range(PoolSize - 1)];
    sample  = ($urandom_range(1)) ? 24'($urandom) : 24'($urandom_range(40000)) - 24'sd20000;
    if ($urandom_range(19) == 0) sample = missing_code;
    if (pick < 58) send_item(OP_ACCUM, cell_id, sample);
    else if (pick < 66) send_item(OP_CLEAR, cell_id, sample);
    else if (pick < 92) send_item(OP_READ, cell_id, sample);
    else send_item(OP_NONE, 12'($urandom), sample);
  endtask

  // Random traffic over a small set of cleared cells spread across the index
  // range, with the missing code changed between chunks.
  task automatic test_random_traffic();
    logic signed [23:0] codes [4];
    codes[0] = -24'sh800000;
    codes[1] = 24'sh7FFFFF;
    codes[2] = 24'($urandom);
    codes[3] = 24'sd0;
    cell_pool[0] = 12'd0;
    cell_pool[1] = 12'd4095;
    cell_pool[2] = 12'hAAA;
    cell_pool[3] = 12'h555;
    for (int i = 4; i < PoolSize; i++) cell_pool[i] = 12'($urandom);
    for (int i = 0; i < PoolSize; i++) send_item(OP_CLEAR, cell_pool[i], '0);
    for (int chunk = 0; chunk < 4; chunk++) begin
      write_missing(codes[chunk]);
      idling_on = (chunk != 2);
      for (int i = 0; i < 190; i++) send_random_item();
    end
    idling_on = 1'b1;
  endtask

  // Result side: random stalls, plus one long hold-off counted here.
  always @(posedge clk_i) begin
    static int unsigned holds_served = 0;
    static int unsigned hold_left = 0;
    if (holdoff_requests != holds_served) begin
      holds_served = holdoff_requests;
      hold_left    = 1500;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !idling_on || ($urandom_range(99) >= 27);
    end
  end

  // Checks each beat against the oldest expectation and runs the watchdog.
  always @(posedge clk_i) begin
    cell_stats_t seen;
    cell_stats_t want;
    if (out_valid_o && out_ready_i) begin
      seen = '{result_cell_o, mean_value_o, deviation_value_o, sample_count_o, has_data_o};
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t unexpected beat cell=%0d mean=%0d dev=%0d count=%0d has=%0b",
                 $time, seen.cell_id, seen.mean, seen.dev, seen.count, seen.has);
      end else begin
        want = pending_stats.pop_front();
        if (seen !== want) begin
          errors++;
          $display("%0t mismatch expected cell=%0d mean=%0d dev=%0d count=%0d has=%0b",
                   $time, want.cell_id, want.mean, want.dev, want.count, want.has);
          $display("%0t          actual   cell=%0d mean=%0d dev=%0d count=%0d has=%0b",
                   $time, seen.cell_id, seen.mean, seen.dev, seen.count, seen.has);
        end
      end
    end
    if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    missing_code = -24'sh800000;
    for (int i = 0; i < Cells; i++) begin
      cell_sum[i]        = 0;
      cell_square_sum[i] = '0;
      cell_count[i]      = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes_and_missing();
    test_unknown_operation();
    test_dense_accumulate();
    test_backpressure();
    test_random_traffic();
    drain_and_settle();
    if (pending_stats.size() == 0 && errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
